/* src/assert_macros.svh */
// Assertion helpers used by the ip_range_table_lookup module.
// They expect signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_ALWAYS(lbl, !(cond), msg)

`else

`define ASSERT_ALWAYS(lbl, prop, msg)

`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

/* src/iprtl_pkg.sv */
package iprtl_pkg;

    localparam int MAX_RANGES = 65536;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    localparam int REGION_W   = 16;
    localparam int HALF_W     = 64;
    localparam int IN_DATA_W  = 6 * HALF_W + REGION_W;
    localparam int IN_USER_W  = 3;
    localparam int STATUS_W   = 3;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_STORED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_HIT     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_MISS    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_CLEARED = 3'd4;

    localparam logic [HALF_W-1:0] V4_MAP_BITS = 64'h0000_FFFF_0000_0000;

    typedef struct packed {
        logic [REGION_W-1:0] region;
        logic [HALF_W-1:0]   end_lo;
        logic [HALF_W-1:0]   end_hi;
        logic [HALF_W-1:0]   start_lo;
        logic [HALF_W-1:0]   start_hi;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic go_right;
        logic go_left;
    } cmp_res_t;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'b0001,
        ST_SRCH_ADDR = 4'b0010,
        ST_SRCH_CMP  = 4'b0100,
        ST_RESP      = 4'b1000
    } state_t;

endpackage

/* src/ip_range_table_lookup.sv */
// Range table with binary search lookup. Appends, clears, table-full drops and
// unused kinds, answered as a miss with the default region, put their result
// in the output register in the cycle after acceptance. A lookup searches the
// n stored entries, 65536 in a full table; each probe reads the single-port
// entry memory and then compares the 128-bit bounds. Items are handled one at
// a time; a new item is accepted while the previous result still waits in the
// output register, as long as that result leaves in time.
// The default region register may be written only while the block is idle.
module ip_range_table_lookup (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [iprtl_pkg::REGION_W-1:0]       cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // addr_hi, addr_lo, from_hi, from_lo, until_hi, until_lo, region_in
    input  logic [iprtl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // kind, v4_form
    input  logic [iprtl_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // region_out
    output logic [iprtl_pkg::REGION_W-1:0]       m_axis_tdata,
    // status
    output logic [iprtl_pkg::STATUS_W-1:0]       m_axis_tuser
);

    localparam int HW = iprtl_pkg::HALF_W;
    localparam int RW = iprtl_pkg::REGION_W;
    localparam int CW = iprtl_pkg::CNT_W;
    localparam int IW = iprtl_pkg::IDX_W;

    iprtl_pkg::state_t          state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              lo_reg, lo_next;
    logic [CW-1:0]              hi_reg, hi_next;
    logic [CW-1:0]              mid_reg, mid_next;
    logic [HW-1:0]              key_hi_reg, key_hi_next;
    logic [HW-1:0]              key_lo_reg, key_lo_next;
    logic [RW-1:0]              dflt_reg, dflt_next;
    logic [iprtl_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [RW-1:0]              res_region_reg, res_region_next;
    logic                       out_valid_reg, out_valid_next;
    logic [iprtl_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [RW-1:0]              out_region_reg, out_region_next;

    logic [1:0]                 in_kind;
    logic                       in_v4;
    logic [HW-1:0]              in_addr_hi, in_addr_lo;
    logic [HW-1:0]              in_from_hi, in_from_lo, in_until_hi, in_until_lo;
    logic [RW-1:0]              in_region;
    logic                       in_accept;
    logic                       slot_free;
    logic [CW:0]                mid_sum;
    logic [CW-1:0]              mid_calc;

    iprtl_pkg::entry_t          wr_entry;
    iprtl_pkg::entry_t          rd_entry;
    logic [iprtl_pkg::ENTRY_W-1:0] rd_word;
    logic                       ram_we;
    logic [IW-1:0]              ram_addr;
    iprtl_pkg::cmp_res_t        cmp_res;

    assign in_kind     = s_axis_tuser[1:0];
    assign in_v4       = s_axis_tuser[2];
    assign in_addr_hi  = s_axis_tdata[HW-1:0];
    assign in_addr_lo  = s_axis_tdata[2*HW-1:HW];
    assign in_from_hi  = s_axis_tdata[3*HW-1:2*HW];
    assign in_from_lo  = s_axis_tdata[4*HW-1:3*HW];
    assign in_until_hi = s_axis_tdata[5*HW-1:4*HW];
    assign in_until_lo = s_axis_tdata[6*HW-1:5*HW];
    assign in_region   = s_axis_tdata[6*HW+RW-1:6*HW];

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == iprtl_pkg::ST_IDLE) && slot_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_region_reg;
    assign m_axis_tuser  = out_status_reg;

    // Midpoint of the half-open window [lo, hi).
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} - {{CW{1'b0}}, 1'b1};
    assign mid_calc = mid_sum[CW:1];

    always_comb
    begin
        wr_entry.region = in_region;
        if (in_v4)
        begin
            wr_entry.start_hi = '0;
            wr_entry.start_lo = iprtl_pkg::V4_MAP_BITS | {32'd0, in_from_lo[31:0]};
            wr_entry.end_hi   = '0;
            wr_entry.end_lo   = iprtl_pkg::V4_MAP_BITS | {32'd0, in_until_lo[31:0]};
        end
        else
        begin
            wr_entry.start_hi = in_from_hi;
            wr_entry.start_lo = in_from_lo;
            wr_entry.end_hi   = in_until_hi;
            wr_entry.end_lo   = in_until_lo;
        end
    end

    assign ram_we   = in_accept && (in_kind == iprtl_pkg::KIND_APPEND)
                      && (count_reg < CW'(iprtl_pkg::MAX_RANGES));
    assign ram_addr = (state_reg == iprtl_pkg::ST_SRCH_ADDR) ? mid_calc[IW-1:0]
                                                             : count_reg[IW-1:0];

    iprtl_ram #(
        .WIDTH (iprtl_pkg::ENTRY_W),
        .DEPTH (iprtl_pkg::MAX_RANGES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wr_entry),
        .rdata (rd_word)
    );

    assign rd_entry = iprtl_pkg::entry_t'(rd_word);

    iprtl_cmp u_cmp (
        .entry   (rd_entry),
        .addr_hi (key_hi_reg),
        .addr_lo (key_lo_reg),
        .res     (cmp_res)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        key_hi_next     = key_hi_reg;
        key_lo_next     = key_lo_reg;
        dflt_next       = cfg_we ? cfg_wdata : dflt_reg;
        res_status_next = res_status_reg;
        res_region_next = res_region_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_region_next = out_region_reg;

        case (state_reg)
            iprtl_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_kind)
                        iprtl_pkg::KIND_APPEND:
                        begin
                            out_valid_next  = 1'b1;
                            out_region_next = '0;
                            if (ram_we)
                            begin
                                count_next      = count_reg + CW'(1);
                                out_status_next = iprtl_pkg::STAT_STORED;
                            end
                            else
                            begin
                                out_status_next = iprtl_pkg::STAT_FULL;
                            end
                        end
                        iprtl_pkg::KIND_LOOKUP:
                        begin
                            lo_next         = '0;
                            hi_next         = count_reg;
                            key_hi_next     = in_addr_hi;
                            key_lo_next     = in_addr_lo;
                            res_status_next = iprtl_pkg::STAT_MISS;
                            res_region_next = dflt_reg;
                            state_next      = iprtl_pkg::ST_SRCH_ADDR;
                        end
                        iprtl_pkg::KIND_CLEAR:
                        begin
                            count_next      = '0;
                            out_valid_next  = 1'b1;
                            out_status_next = iprtl_pkg::STAT_CLEARED;
                            out_region_next = '0;
                        end
                        default:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = iprtl_pkg::STAT_MISS;
                            out_region_next = dflt_reg;
                        end
                    endcase
                end
            end
            iprtl_pkg::ST_SRCH_ADDR:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = iprtl_pkg::ST_SRCH_CMP;
                end
                else
                begin
                    state_next = iprtl_pkg::ST_RESP;
                end
            end
            iprtl_pkg::ST_SRCH_CMP:
            begin
                if (cmp_res.go_right)
                begin
                    lo_next    = mid_reg + CW'(1);
                    state_next = iprtl_pkg::ST_SRCH_ADDR;
                end
                else if (cmp_res.go_left)
                begin
                    hi_next    = mid_reg;
                    state_next = iprtl_pkg::ST_SRCH_ADDR;
                end
                else
                begin
                    res_status_next = iprtl_pkg::STAT_HIT;
                    res_region_next = rd_entry.region;
                    state_next      = iprtl_pkg::ST_RESP;
                end
            end
            iprtl_pkg::ST_RESP:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_region_next = res_region_reg;
                    state_next      = iprtl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iprtl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iprtl_pkg::ST_IDLE;
            count_reg     <= '0;
            dflt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dflt_reg      <= dflt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        key_hi_reg     <= key_hi_next;
        key_lo_reg     <= key_lo_next;
        res_status_reg <= res_status_next;
        res_region_reg <= res_region_next;
        out_status_reg <= out_status_next;
        out_region_reg <= out_region_next;
    end

`include "assert_macros.svh"

    `ASSERT_NEVER(a_count_bound, count_reg > CW'(iprtl_pkg::MAX_RANGES), "entry count overflow")
    `ASSERT_ALWAYS(a_window, (state_reg == iprtl_pkg::ST_SRCH_CMP) |-> (lo_reg <= mid_reg && mid_reg < hi_reg && hi_reg <= count_reg), "search window out of range")
    `ASSERT_ALWAYS(a_clear, (in_accept && in_kind == iprtl_pkg::KIND_CLEAR) |=> (count_reg == '0 && out_valid_reg), "clear did not empty the table")
    `ASSERT_ALWAYS(a_lookup_start, (in_accept && in_kind == iprtl_pkg::KIND_LOOKUP) |=> (state_reg == iprtl_pkg::ST_SRCH_ADDR && lo_reg == '0), "lookup did not start a search")

endmodule

/* src/iprtl_ram.sv */
module iprtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* src/iprtl_cmp.sv */
module iprtl_cmp (
    input  iprtl_pkg::entry_t                  entry,
    input  logic [iprtl_pkg::HALF_W-1:0]       addr_hi,
    input  logic [iprtl_pkg::HALF_W-1:0]       addr_lo,
    output iprtl_pkg::cmp_res_t                res
);

    logic end_below;
    logic start_above;

    assign end_below   = {entry.end_hi, entry.end_lo} < {addr_hi, addr_lo};
    assign start_above = {entry.start_hi, entry.start_lo} > {addr_hi, addr_lo};

    assign res.go_right = end_below;
    assign res.go_left  = !end_below && start_above;

endmodule

/* test/tb_ip_range_table_lookup.sv */
`timescale 1ns / 100ps

module tb_ip_range_table_lookup;

    localparam int STUCK_LIMIT = 4000;
    localparam int PRINT_LIMIT = 40;
    localparam int IW          = iprtl_pkg::IDX_W;

    typedef logic [iprtl_pkg::REGION_W-1:0] region_t;
    typedef logic [iprtl_pkg::STATUS_W-1:0] status_t;

    typedef struct packed {
        logic [1:0]   kind;
        logic         v4_form;
        logic [127:0] addr;
        logic [127:0] start_addr;
        logic [127:0] end_addr;
        region_t      region;
    } req_t;

    typedef struct packed {
        status_t status;
        region_t region;
    } outcome_t;

    typedef struct packed {
        req_t    req;
        logic    fixed;
        status_t status;
        region_t region;
    } stim_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    region_t                         cfg_wdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [iprtl_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [iprtl_pkg::IN_USER_W-1:0] s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    region_t                         m_axis_tdata;
    status_t                         m_axis_tuser;

    bit [127:0] range_start [iprtl_pkg::MAX_RANGES];
    bit [127:0] range_end [iprtl_pkg::MAX_RANGES];
    region_t    range_region [iprtl_pkg::MAX_RANGES];
    int         range_count = 0;
    region_t    default_id = '0;

    outcome_t  expected_results[$];
    outcome_t  head;
    stim_row_t directed_rows[$];
    int        issued_count = 0;
    int        mismatch_count = 0;
    int        stuck_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        hold_off = 1'b0;

    ip_range_table_lookup dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic req_t random_req(input logic [1:0] kind);
        req_t r;
        r.kind       = kind;
        r.v4_form    = 1'($urandom_range(0, 1));
        r.addr       = rand128();
        r.start_addr = rand128();
        r.end_addr   = rand128();
        r.region     = region_t'($urandom);
        return r;
    endfunction

    function automatic stim_row_t mk_row(input logic [1:0] kind, input logic v4,
                                         input logic [127:0] addr,
                                         input logic [127:0] start_addr,
                                         input logic [127:0] end_addr,
                                         input region_t region,
                                         input logic fixed = 1'b0,
                                         input status_t status = iprtl_pkg::STAT_STORED,
                                         input region_t region_out = '0);
        stim_row_t row;
        row.req.kind       = kind;
        row.req.v4_form    = v4;
        row.req.addr       = addr;
        row.req.start_addr = start_addr;
        row.req.end_addr   = end_addr;
        row.req.region     = region;
        row.fixed          = fixed;
        row.status         = status;
        row.region         = region_out;
        return row;
    endfunction

    // Applies one request to the shadow table and returns the response it must produce.
    function automatic outcome_t predict_item(input req_t r);
        outcome_t   o;
        int         lo;
        int         hi;
        int         mid;
        bit [127:0] s;
        bit [127:0] e;
        o.status = iprtl_pkg::STAT_MISS;
        o.region = default_id;
        case (r.kind)
            iprtl_pkg::KIND_APPEND:
            begin
                o.region = '0;
                if (range_count >= iprtl_pkg::MAX_RANGES)
                begin
                    o.status = iprtl_pkg::STAT_FULL;
                end
                else
                begin
                    s = r.start_addr;
                    e = r.end_addr;
                    if (r.v4_form)
                    begin
                        s = {64'h0, iprtl_pkg::V4_MAP_BITS | {32'h0, s[31:0]}};
                        e = {64'h0, iprtl_pkg::V4_MAP_BITS | {32'h0, e[31:0]}};
                    end
                    range_start[range_count[IW-1:0]]  = s;
                    range_end[range_count[IW-1:0]]    = e;
                    range_region[range_count[IW-1:0]] = r.region;
                    range_count++;
                    o.status = iprtl_pkg::STAT_STORED;
                end
            end
            iprtl_pkg::KIND_LOOKUP:
            begin
                lo = 0;
                hi = range_count - 1;
                while (lo <= hi)
                begin
                    mid = (lo + hi) / 2;
                    if (range_end[mid[IW-1:0]] < r.addr)
                        lo = mid + 1;
                    else if (range_start[mid[IW-1:0]] > r.addr)
                        hi = mid - 1;
                    else
                    begin
                        o.status = iprtl_pkg::STAT_HIT;
                        o.region = range_region[mid[IW-1:0]];
                        break;
                    end
                end
            end
            iprtl_pkg::KIND_CLEAR:
            begin
                range_count = 0;
                o.status    = iprtl_pkg::STAT_CLEARED;
                o.region    = '0;
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    function automatic bit [127:0] probe_addr();
        int         idx;
        bit [127:0] s;
        bit [127:0] e;
        bit [127:0] t;
        if (range_count == 0 || $urandom_range(0, 7) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
                return rand128();
            return {64'h0, iprtl_pkg::V4_MAP_BITS | {32'h0, $urandom}};
        end
        idx = int'($urandom_range(0, range_count - 1));
        s   = range_start[idx[IW-1:0]];
        e   = range_end[idx[IW-1:0]];
        case ($urandom_range(0, 4))
            0: return s;
            1: return e;
            2: return e + 128'd1;
            3: return s - 128'd1;
            default:
            begin
                t = s + (rand128() >> $urandom_range(0, 127));
                if (t < s || t > e)
                    t = e;
                return t;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_item(input req_t r, input logic fixed = 1'b0,
                             input status_t status = iprtl_pkg::STAT_STORED,
                             input region_t region = '0);
        outcome_t o;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.region, r.end_addr[63:0], r.end_addr[127:64],
                          r.start_addr[63:0], r.start_addr[127:64],
                          r.addr[63:0], r.addr[127:64]};
        s_axis_tuser  <= {r.v4_form, r.kind};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        o = predict_item(r);
        if (fixed)
        begin
            o.status = status;
            o.region = region;
        end
        expected_results.push_back(o);
        issued_count++;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_default_region(input region_t value);
        wait_drained();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we     <= 1'b0;
        default_id = value;
    endtask

    // Mostly clean tables of ascending ranges probed near their bounds, with some noise
    // transactions and some tables loaded with arbitrary, possibly unordered ranges.
    task automatic run_random(input int n_items);
        int         target;
        int         pick;
        int         n_app;
        int         n_look;
        bit         v4_seq;
        bit [127:0] cursor;
        bit [32:0]  c32;
        bit [32:0]  f32;
        bit [32:0]  u32;
        req_t       r;
        target = issued_count + n_items;
        while (issued_count < target)
        begin
            pick = int'($urandom_range(0, 99));
            if (pick < 15)
            begin
                send_item(random_req(2'($urandom_range(0, 3))));
            end
            else
            begin
                if (pick < 85)
                begin
                    send_item(random_req(iprtl_pkg::KIND_CLEAR));
                    n_app  = int'($urandom_range(1, 24));
                    v4_seq = ($urandom_range(0, 2) == 0);
                    cursor = rand128() >> $urandom_range(2, 127);
                    c32    = {1'b0, $urandom >> $urandom_range(1, 31)};
                    for (int k = 0; k < n_app; k++)
                    begin
                        r         = random_req(iprtl_pkg::KIND_APPEND);
                        r.v4_form = v4_seq;
                        if (v4_seq)
                        begin
                            f32 = c32 + {1'b0, $urandom >> $urandom_range(8, 31)};
                            u32 = f32 + {1'b0, $urandom >> $urandom_range(8, 31)};
                            if (u32[32])
                                break;
                            r.start_addr[31:0] = f32[31:0];
                            r.end_addr[31:0]   = u32[31:0];
                            c32 = u32 + 33'd1;
                        end
                        else
                        begin
                            r.start_addr = cursor + (rand128() >> $urandom_range(64, 127));
                            r.end_addr   = r.start_addr
                                           + (rand128() >> $urandom_range(64, 127));
                            cursor       = r.end_addr + 128'd1;
                        end
                        send_item(r);
                    end
                end
                else
                begin
                    n_app = int'($urandom_range(1, 8));
                    for (int k = 0; k < n_app; k++)
                        send_item(random_req(iprtl_pkg::KIND_APPEND));
                end
                n_look = int'($urandom_range(4, 16));
                for (int k = 0; k < n_look; k++)
                begin
                    r      = random_req(iprtl_pkg::KIND_LOOKUP);
                    r.addr = probe_addr();
                    send_item(r);
                end
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result, status", 32'(m_axis_tuser), '0);
            end
            else
            begin
                head = expected_results.pop_front();
                if (m_axis_tuser !== head.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(head.status));
                if (m_axis_tdata !== head.region)
                    report_mismatch("region", 32'(m_axis_tdata), 32'(head.region));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (!s_axis_tvalid && expected_results.size() == 0))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        req_t r;

        directed_rows.push_back(mk_row(iprtl_pkg::KIND_LOOKUP, 1'b0, '1, '0, '0, '0,
                                       1'b1, iprtl_pkg::STAT_MISS, 16'h0000));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_UNUSED, 1'b1, '1, '1, '1, 16'hffff,
                                       1'b1, iprtl_pkg::STAT_MISS, 16'h0000));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_APPEND, 1'b0, '0, '0, '0, 16'hffff,
                                       1'b1, iprtl_pkg::STAT_STORED, 16'h0000));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_APPEND, 1'b1, '0,
                                       128'hffff_ffff_ffff_ffff_dead_beef_0a00_0000,
                                       128'h1234_5678_9abc_def0_ffff_ffff_0a00_00ff,
                                       16'h0001, 1'b1, iprtl_pkg::STAT_STORED, 16'h0000));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_APPEND, 1'b0, '0,
                                       128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_fffe, '1,
                                       16'h8000, 1'b1, iprtl_pkg::STAT_STORED, 16'h0000));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_LOOKUP, 1'b0, '0, '1, '1, '0,
                                       1'b1, iprtl_pkg::STAT_HIT, 16'hffff));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_LOOKUP, 1'b1, '1, '0, '0, '0,
                                       1'b1, iprtl_pkg::STAT_HIT, 16'h8000));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_LOOKUP, 1'b0, 128'd1, '0, '0, '0));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_LOOKUP, 1'b0,
                                       128'h0000_ffff_0a00_0000, '0, '0, '0));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_LOOKUP, 1'b0,
                                       128'h0000_ffff_0a00_00ff, '0, '0, '0));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_LOOKUP, 1'b0,
                                       128'h0000_ffff_0a00_0100, '0, '0, '0));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_LOOKUP, 1'b0,
                                       128'hdead_beef_0a00_0010, '0, '0, '0));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_LOOKUP, 1'b0,
                                       128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_fffd,
                                       '0, '0, '0));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_CLEAR, 1'b0, '1, '1, '1, 16'hffff,
                                       1'b1, iprtl_pkg::STAT_CLEARED, 16'h0000));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_LOOKUP, 1'b0, '0, '0, '0, '0,
                                       1'b1, iprtl_pkg::STAT_MISS, 16'h0000));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_APPEND, 1'b0, '0,
                                       128'd100, 128'd200, 16'h0007));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_APPEND, 1'b0, '0,
                                       128'd0, 128'd50, 16'h0009));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_APPEND, 1'b0, '0,
                                       128'd300, 128'd250, 16'h000b));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_LOOKUP, 1'b0, 128'd150, '0, '0, '0));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_LOOKUP, 1'b0, 128'd25, '0, '0, '0));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_LOOKUP, 1'b0, 128'd260, '0, '0, '0));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_APPEND, 1'b1, '0, '0,
                                       128'hffff_ffff, 16'h00c3));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_LOOKUP, 1'b0,
                                       128'h0000_ffff_ffff_ffff, '0, '0, '0));
        directed_rows.push_back(mk_row(iprtl_pkg::KIND_CLEAR, 1'b0, '0, '0, '0, '0,
                                       1'b1, iprtl_pkg::STAT_CLEARED, 16'h0000));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_default_region(16'h0000);
        foreach (directed_rows[i])
            send_item(directed_rows[i].req, directed_rows[i].fixed,
                      directed_rows[i].status, directed_rows[i].region);
        s_axis_tvalid <= 1'b0;

        set_default_region(16'hffff);
        run_random(300);

        set_default_region(region_t'($urandom));
        send_idle_pct = 87;
        run_random(300);

        set_default_region(region_t'($urandom));
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        run_random(300);

        set_default_region(16'h0001);
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        run_random(300);

        // The receiver holds off while the sender keeps offering, so the block backs up.
        set_default_region(region_t'($urandom));
        send_idle_pct = 0;
        fork
            run_random(300);
            begin
                repeat (60) @(posedge clk);
                hold_off <= 1'b1;
                repeat (400) @(posedge clk);
                hold_off <= 1'b0;
            end
        join

        // A short table of wide ranges that start at the bottom of the address space.
        set_default_region(16'habcd);
        recv_stall_pct = 0;
        send_item(random_req(iprtl_pkg::KIND_CLEAR));
        for (int i = 0; i < 8; i++)
        begin
            r            = random_req(iprtl_pkg::KIND_APPEND);
            r.v4_form    = 1'b0;
            r.start_addr = {i[15:0], 112'h0};
            r.end_addr   = {i[15:0], 1'b0, {111{1'b1}}};
            r.region     = i[15:0] ^ 16'h5a5a;
            send_item(r);
        end
        for (int i = 0; i < 16; i++)
        begin
            r      = random_req(iprtl_pkg::KIND_LOOKUP);
            r.addr = probe_addr();
            send_item(r);
        end
        send_item(random_req(iprtl_pkg::KIND_UNUSED));
        send_item(random_req(iprtl_pkg::KIND_CLEAR));
        send_item(random_req(iprtl_pkg::KIND_LOOKUP));
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
